FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the error function unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EFA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Same-cycle implication check failed.");

// Next-cycle implication, disabled during reset.
`define EFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Next-cycle implication check failed.");

`endif

FILE: hw/rtl/efa_pkg.sv
// ----------------------------------------------------------------------------
// Error function unit package
// Fixed-point widths, constants and the sideband type shared by the pipeline.
// ----------------------------------------------------------------------------
package efa_pkg;

  // Number formats.
  localparam int ARG_FRAC_BITS    = 12;
  localparam int RESULT_FRAC_BITS = 14;
  localparam int QB               = 30;
  localparam int DATA_W           = 16;

  // Internal widths.
  localparam int MAG_W  = 17;
  localparam int REM_W  = 17;
  localparam int QUO_W  = 32;
  localparam int T_W    = 31;
  localparam int P_W    = 34;
  localparam int SQ_W   = 36;
  localparam int E_W    = 38;
  localparam int K_W    = 10;
  localparam int R_W    = 30;
  localparam int TERM_W = 31;
  localparam int SUM_W  = 32;
  localparam int EX_W   = 34;

  localparam int POLY_DEG     = 9;
  localparam int TAYLOR_TERMS = 20;

  localparam longint ONE_Q      = longint'(1) << QB;
  localparam longint LN2_Q      = 744261118;
  localparam longint COEF_SCALE = 100000000;

  // Front end constants.
  localparam logic [MAG_W-1:0] LARGE_LIM = MAG_W'(6 << ARG_FRAC_BITS);
  localparam logic [MAG_W-1:0] DEN_BASE  = MAG_W'(2 << ARG_FRAC_BITS);
  localparam int SQ_SHIFT = QB - 2 * ARG_FRAC_BITS;

  // The divider starts from the numerator bits above the quotient width.
  localparam int DIV_INIT_EXP = QB + 2 + ARG_FRAC_BITS - QUO_W;
  localparam logic [REM_W-1:0] DIV_INIT_REM = REM_W'(1 << DIV_INIT_EXP);

  // Range reduction k = floor(e / ln2) via a scaled reciprocal.
  localparam int K_EH_SHIFT   = 16;
  localparam int K_PROD_SHIFT = 32;
  localparam int K_RECIP_W    = 20;
  localparam longint K_RECIP  = (longint'(1) << (K_PROD_SHIFT + K_EH_SHIFT)) / LN2_Q;

  // Output rounding.
  localparam int RES_SHIFT = QB - RESULT_FRAC_BITS;
  localparam logic [DATA_W-1:0] RES_LIM = DATA_W'(1 << RESULT_FRAC_BITS);

  // Polynomial coefficients scaled by 1e8, lowest order first.
  localparam longint COEF_E8 [POLY_DEG+1] = '{
    -126551223, 100002368, 37409196, 9678418, -18628806,
    27886807, -113520398, 148851587, -82215223, 17087277
  };

  // Sideband that travels with each item through the pipeline.
  typedef struct packed {
    logic            neg;
    logic            sat_one;
    logic [SQ_W-1:0] sq;
    logic [T_W-1:0]  t;
  } efa_side_t;

  // Coefficient in Q30, rounded half away from zero.
  function automatic logic signed [P_W-1:0] coef_q(input longint c);
    longint m;
    longint q;
    m = (c < 0) ? -c : c;
    q = ((m <<< QB) + COEF_SCALE / 2) / COEF_SCALE;
    return (c < 0) ? P_W'(-q) : P_W'(q);
  endfunction

endpackage

FILE: hw/rtl/efa_recip.sv
// ----------------------------------------------------------------------------
// Reciprocal pipeline
// Computes t = round(2^43 / den) in Q30, two quotient bits per stage.
// ----------------------------------------------------------------------------
module efa_recip import efa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [MAG_W-1:0] in_den,
  input  efa_side_t        in_side,
  output logic             out_valid,
  output efa_side_t        out_side
);

  localparam int BITS_PER_STG = 2;
  localparam int NSTG = QUO_W / BITS_PER_STG;

  logic             st_valid [NSTG];
  logic [REM_W-1:0] st_rem   [NSTG];
  logic [QUO_W-1:0] st_quo   [NSTG];
  logic [MAG_W-1:0] st_den   [NSTG];
  efa_side_t        st_side  [NSTG];

  logic [QUO_W:0]   quo_inc;
  efa_side_t        side_fin;

  // Restoring division stages.
  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [MAG_W-1:0] den_in;
    efa_side_t        side_in;
    logic [REM_W-1:0] rem_c;
    logic [QUO_W-1:0] quo_c;
    logic [REM_W:0]   trial;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = DIV_INIT_REM;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = st_valid[s-1];
      assign rem_in  = st_rem[s-1];
      assign quo_in  = st_quo[s-1];
      assign den_in  = st_den[s-1];
      assign side_in = st_side[s-1];
    end

    // Shift in a zero numerator bit, then compare and subtract.
    always_comb begin
      rem_c = rem_in;
      quo_c = quo_in;
      trial = '0;
      for (int b = 0; b < BITS_PER_STG; b++) begin
        trial = {rem_c, 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_c = REM_W'(trial - {1'b0, den_in});
          quo_c = {quo_c[QUO_W-2:0], 1'b1};
        end else begin
          rem_c = REM_W'(trial);
          quo_c = {quo_c[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s] <= 1'b0;
      end else if (en) begin
        st_valid[s] <= v_in;
      end
      if (en) begin
        st_rem[s]  <= rem_c;
        st_quo[s]  <= quo_c;
        st_den[s]  <= den_in;
        st_side[s] <= side_in;
      end
    end
  end

  // Round the doubled quotient to the final reciprocal.
  assign quo_inc = {1'b0, st_quo[NSTG-1]} + (QUO_W+1)'(1);

  always_comb begin
    side_fin   = st_side[NSTG-1];
    side_fin.t = quo_inc[T_W:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_valid[NSTG-1];
    end
    if (en) begin
      out_side <= side_fin;
    end
  end

endmodule

FILE: hw/rtl/efa_horner.sv
// ----------------------------------------------------------------------------
// Polynomial pipeline
// Evaluates the degree-nine polynomial in t by Horner's rule, two stages a step.
// ----------------------------------------------------------------------------
module efa_horner import efa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  efa_side_t             in_side,
  output logic                  out_valid,
  output logic signed [P_W-1:0] out_poly,
  output efa_side_t             out_side
);

  localparam int STEPS  = POLY_DEG;
  localparam int PROD_W = P_W - 1 + T_W;

  logic                  mul_valid [STEPS];
  logic [PROD_W-1:0]     mul_prod  [STEPS];
  logic                  mul_neg   [STEPS];
  efa_side_t             mul_side  [STEPS];
  logic                  add_valid [STEPS];
  logic signed [P_W-1:0] add_poly  [STEPS];
  efa_side_t             add_side  [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic signed [P_W-1:0] CJ = coef_q(COEF_E8[POLY_DEG-1-j]);
    logic                  v_in;
    logic signed [P_W-1:0] p_in;
    efa_side_t             side_in;
    logic [P_W-1:0]        p_neg;
    logic [P_W-2:0]        p_mag;
    logic [P_W-1:0]        rnd;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign p_in    = coef_q(COEF_E8[POLY_DEG]);
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = add_valid[j-1];
      assign p_in    = add_poly[j-1];
      assign side_in = add_side[j-1];
    end

    // Magnitude times t.
    assign p_neg = -p_in;
    assign p_mag = p_in[P_W-1] ? p_neg[P_W-2:0] : p_in[P_W-2:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        mul_valid[j] <= 1'b0;
      end else if (en) begin
        mul_valid[j] <= v_in;
      end
      if (en) begin
        mul_prod[j] <= p_mag * side_in.t;
        mul_neg[j]  <= p_in[P_W-1];
        mul_side[j] <= side_in;
      end
    end

    // Round half away from zero, restore the sign, add the coefficient.
    assign rnd = P_W'(mul_prod[j][PROD_W-1:QB]) + P_W'(mul_prod[j][QB-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        add_valid[j] <= 1'b0;
      end else if (en) begin
        add_valid[j] <= mul_valid[j];
      end
      if (en) begin
        add_poly[j] <= CJ + (mul_neg[j] ? -rnd : rnd);
        add_side[j] <= mul_side[j];
      end
    end
  end

  assign out_valid = add_valid[STEPS-1];
  assign out_poly  = add_poly[STEPS-1];
  assign out_side  = add_side[STEPS-1];

endmodule

FILE: hw/rtl/efa_exp.sv
// ----------------------------------------------------------------------------
// Exponential pipeline
// Forms e = P - x^2, reduces it by ln2 and sums a 20-term Taylor series.
// ----------------------------------------------------------------------------
module efa_exp import efa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [P_W-1:0] in_poly,
  input  efa_side_t             in_side,
  output logic                  out_valid,
  output logic [EX_W-1:0]       out_exp,
  output efa_side_t             out_side
);

  localparam int EH_W    = E_W - K_EH_SHIFT;
  localparam int KP_W    = EH_W + K_RECIP_W;
  localparam int KL_W    = K_W + R_W + 1;
  localparam int RR_W    = E_W + 4;
  localparam int TP_W    = TERM_W + R_W;
  localparam int MR_W    = 32;
  localparam int QP_W    = TERM_W + MR_W;
  localparam int ZERO_SH = 62;
  localparam int SH_W    = 6;

  localparam logic signed [K_RECIP_W-1:0] KREC_S = K_RECIP_W'(K_RECIP);
  localparam logic signed [R_W:0]         LN2_K  = (R_W+1)'(LN2_Q);
  localparam logic signed [RR_W-1:0]      LN2_R  = RR_W'(LN2_Q);

  typedef struct packed {
    efa_side_t              side;
    logic [R_W-1:0]         r;
    logic signed [K_W-1:0]  k;
    logic [SUM_W-1:0]       sum;
    logic [TERM_W-1:0]      term;
  } tay_t;

  // Exponent argument.
  logic                   e0_valid;
  logic signed [E_W-1:0]  e0_e;
  efa_side_t              e0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_valid <= 1'b0;
    end else if (en) begin
      e0_valid <= in_valid;
    end
    if (en) begin
      e0_e    <= E_W'(in_poly) - E_W'(in_side.sq);
      e0_side <= in_side;
    end
  end

  // Scaled reciprocal product for k.
  logic                   e1_valid;
  logic signed [E_W-1:0]  e1_e;
  logic signed [KP_W-1:0] e1_kp;
  efa_side_t              e1_side;
  logic signed [EH_W-1:0] eh;

  assign eh = e0_e[E_W-1:K_EH_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else if (en) begin
      e1_valid <= e0_valid;
    end
    if (en) begin
      e1_e    <= e0_e;
      e1_kp   <= eh * KREC_S;
      e1_side <= e0_side;
    end
  end

  // Estimate of k and k * ln2.
  logic                   e2_valid;
  logic signed [E_W-1:0]  e2_e;
  logic signed [K_W-1:0]  e2_k;
  logic signed [KL_W-1:0] e2_klp;
  efa_side_t              e2_side;
  logic signed [K_W-1:0]  k_est;

  assign k_est = e1_kp[K_PROD_SHIFT+K_W-1:K_PROD_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
    end else if (en) begin
      e2_valid <= e1_valid;
    end
    if (en) begin
      e2_e    <= e1_e;
      e2_k    <= k_est;
      e2_klp  <= k_est * LN2_K;
      e2_side <= e1_side;
    end
  end

  // Remainder with a one-step correction of k.
  logic                   e3_valid;
  tay_t                   e3_st;
  logic signed [RR_W-1:0] r0;
  tay_t                   red_c;

  assign r0 = RR_W'(e2_e) - RR_W'(e2_klp);

  always_comb begin
    red_c.side = e2_side;
    red_c.sum  = SUM_W'(ONE_Q);
    red_c.term = TERM_W'(ONE_Q);
    if (r0 < 0) begin
      red_c.r = R_W'(r0 + LN2_R);
      red_c.k = e2_k - K_W'(1);
    end else if (r0 >= LN2_R) begin
      red_c.r = R_W'(r0 - LN2_R);
      red_c.k = e2_k + K_W'(1);
    end else begin
      red_c.r = R_W'(r0);
      red_c.k = e2_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e3_valid <= 1'b0;
    end else if (en) begin
      e3_valid <= e2_valid;
    end
    if (en) begin
      e3_st <= red_c;
    end
  end

  // Taylor series, three stages per term.
  logic              a_valid [TAYLOR_TERMS];
  tay_t              a_st    [TAYLOR_TERMS];
  logic [TP_W-1:0]   a_prod  [TAYLOR_TERMS];
  logic              b_valid [TAYLOR_TERMS];
  tay_t              b_st    [TAYLOR_TERMS];
  logic [QP_W-1:0]   b_prod  [TAYLOR_TERMS];
  logic              c_valid [TAYLOR_TERMS];
  tay_t              c_st    [TAYLOR_TERMS];

  for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_term
    localparam int N_T = i + 1;
    localparam int L_T = $clog2(N_T);
    localparam logic [MR_W-1:0] MREC =
      MR_W'(((64'd1 << (TERM_W + L_T)) + 64'(N_T) - 64'd1) / 64'(N_T));
    localparam logic [TERM_W-1:0] HALF_N = TERM_W'(N_T / 2);
    logic              v_in;
    tay_t              st_in;
    logic [TERM_W-1:0] rnd;
    logic [TERM_W-1:0] quo;
    tay_t              st_next;

    if (i == 0) begin : g_first
      assign v_in  = e3_valid;
      assign st_in = e3_st;
    end else begin : g_next
      assign v_in  = c_valid[i-1];
      assign st_in = c_st[i-1];
    end

    // term * r
    always_ff @(posedge clk) begin
      if (rst) begin
        a_valid[i] <= 1'b0;
      end else if (en) begin
        a_valid[i] <= v_in;
      end
      if (en) begin
        a_prod[i] <= st_in.term * st_in.r;
        a_st[i]   <= st_in;
      end
    end

    // Round, add n/2, multiply by the reciprocal of n.
    assign rnd = TERM_W'(a_prod[i][TP_W-1:QB]) + TERM_W'(a_prod[i][QB-1]) + HALF_N;

    always_ff @(posedge clk) begin
      if (rst) begin
        b_valid[i] <= 1'b0;
      end else if (en) begin
        b_valid[i] <= a_valid[i];
      end
      if (en) begin
        b_prod[i] <= rnd * MREC;
        b_st[i]   <= a_st[i];
      end
    end

    // Quotient is the new term; accumulate.
    assign quo = TERM_W'(b_prod[i] >> (TERM_W + L_T));

    always_comb begin
      st_next      = b_st[i];
      st_next.term = quo;
      st_next.sum  = b_st[i].sum + SUM_W'(quo);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        c_valid[i] <= 1'b0;
      end else if (en) begin
        c_valid[i] <= b_valid[i];
      end
      if (en) begin
        c_st[i] <= st_next;
      end
    end
  end

  // Scale by 2^k, with k capped at two, rounding on right shifts.
  tay_t                  fin;
  logic signed [K_W-1:0] nk;
  logic [SUM_W:0]        sh_ext;
  logic [EX_W-1:0]       ex_c;

  assign fin = c_st[TAYLOR_TERMS-1];
  assign nk  = -fin.k;

  always_comb begin
    sh_ext = {fin.sum, 1'b0} >> nk[SH_W-1:0];
    if (!fin.k[K_W-1]) begin
      if (fin.k > K_W'(1)) begin
        ex_c = EX_W'(fin.sum) << 2;
      end else begin
        ex_c = EX_W'(fin.sum) << fin.k[0];
      end
    end else if (nk >= K_W'(ZERO_SH)) begin
      ex_c = '0;
    end else begin
      ex_c = EX_W'(sh_ext[SUM_W:1]) + EX_W'(sh_ext[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid[TAYLOR_TERMS-1];
    end
    if (en) begin
      out_exp  <= ex_c;
      out_side <= fin.side;
    end
  end

endmodule

FILE: hw/rtl/error_function_approx_unit.sv
// ----------------------------------------------------------------------------
// Error function approximation unit
// Pipelined erf(x) for a Q3.12 argument, result in Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per handshake, s_tdata holds the argument x
//   as signed Q3.12. Output channel m_*: one item per input item, in order,
//   m_tdata holds erf(x) as signed Q1.14, saturated to plus or minus one.
//   Throughput is one item per clock cycle unless the receiver stalls.
//   The pipeline holds the 16-stage reciprocal divider, the nine Horner
//   steps and the twenty Taylor terms of the exponential, each with its own
//   pipeline stages; each Horner step owns one multiplier and each Taylor
//   term two, while the divider stages use none.
//   When the receiver stalls, one more item drains into a skid register and
//   then the whole pipeline freezes, with s_tready low, until the output is
//   taken; nothing is lost or repeated. Reset clears every valid bit, so the
//   unit comes out of reset empty and ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module error_function_approx_unit import efa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [15:0] arg_value
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata    // [15:0] erf_value
);

  localparam int MP_W = T_W + EX_W;
  localparam int EC_W = MP_W - QB;

  logic en;
  logic sk_valid;
  logic [DATA_W-1:0] sk_data;

  // The pipeline runs while the skid register is free.
  assign en       = ~sk_valid;
  assign s_tready = en;

  // Front stage: magnitude, sign, range check, denominator and x^2.
  logic              f_valid;
  logic [MAG_W-1:0]  f_den;
  efa_side_t         f_side;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mag_neg;
  efa_side_t         side_c;

  assign mag_neg = MAG_W'(1 << DATA_W) - {1'b0, s_tdata};
  assign mag     = s_tdata[DATA_W-1] ? mag_neg : {1'b0, s_tdata};

  always_comb begin
    side_c.neg     = s_tdata[DATA_W-1];
    side_c.sat_one = (mag >= LARGE_LIM);
    side_c.sq      = SQ_W'(mag[DATA_W-2:0] * mag[DATA_W-2:0]) << SQ_SHIFT;
    side_c.t       = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= s_tvalid;
    end
    if (en) begin
      f_den  <= DEN_BASE + mag;
      f_side <= side_c;
    end
  end

  // Reciprocal t.
  logic      r_valid;
  efa_side_t r_side;

  efa_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_den    (f_den),
    .in_side   (f_side),
    .out_valid (r_valid),
    .out_side  (r_side)
  );

  // Polynomial in t.
  logic                  h_valid;
  logic signed [P_W-1:0] h_poly;
  efa_side_t             h_side;

  efa_horner u_horner (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .in_side   (r_side),
    .out_valid (h_valid),
    .out_poly  (h_poly),
    .out_side  (h_side)
  );

  // exp(P - x^2).
  logic            x_valid;
  logic [EX_W-1:0] x_exp;
  efa_side_t       x_side;

  efa_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (h_valid),
    .in_poly   (h_poly),
    .in_side   (h_side),
    .out_valid (x_valid),
    .out_exp   (x_exp),
    .out_side  (x_side)
  );

  // erfc = t * exp(...).
  logic            mp_valid;
  logic [MP_W-1:0] mp_prod;
  logic            mp_neg;
  logic            mp_sat_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      mp_valid <= 1'b0;
    end else if (en) begin
      mp_valid <= x_valid;
    end
    if (en) begin
      mp_prod    <= x_side.t * x_exp;
      mp_neg     <= x_side.neg;
      mp_sat_one <= x_side.sat_one;
    end
  end

  // One minus erfc, rounding to the output format, saturation and sign.
  logic [EC_W-1:0]   erfc;
  logic [QB:0]       absq;
  logic [DATA_W-1:0] res_mag;
  logic [DATA_W-1:0] res_sat;
  logic [DATA_W-1:0] fin_res;

  assign erfc = EC_W'(mp_prod[MP_W-1:QB]) + EC_W'(mp_prod[QB-1]);

  always_comb begin
    if (mp_sat_one) begin
      absq = (QB+1)'(ONE_Q);
    end else if (erfc > EC_W'(ONE_Q)) begin
      absq = '0;
    end else begin
      absq = (QB+1)'(EC_W'(ONE_Q) - erfc);
    end
    res_mag = DATA_W'(absq >> RES_SHIFT) + DATA_W'(absq[RES_SHIFT-1]);
    res_sat = (res_mag > RES_LIM) ? RES_LIM : res_mag;
    fin_res = mp_neg ? -res_sat : res_sat;
  end

  // Output register with a one-item skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (sk_valid) begin
        m_tvalid <= 1'b1;
        m_tdata  <= sk_data;
        sk_valid <= 1'b0;
      end else begin
        m_tvalid <= mp_valid;
        m_tdata  <= fin_res;
      end
    end else if (mp_valid && en) begin
      sk_valid <= 1'b1;
      sk_data  <= fin_res;
    end
  end

  // Checks.
  `EFA_ASSERT_IMPLY(a_skid_behind_out, clk, rst, sk_valid, m_tvalid)
  `EFA_ASSERT_NEXT(a_skid_held, clk, rst, sk_valid && !(m_tvalid && m_tready), sk_valid)
  `EFA_ASSERT_IMPLY(a_out_range, clk, rst, m_tvalid, ($signed(m_tdata) <= $signed(RES_LIM)) && ($signed(m_tdata) >= -$signed(RES_LIM)))
  `EFA_ASSERT_IMPLY(a_large_pos_one, clk, rst, mp_valid && mp_sat_one && !mp_neg, fin_res == RES_LIM)

endmodule

FILE: bench/tb_error_function_approx_unit.sv
// ----------------------------------------------------------------------------
// Error function unit testbench
// Drives signed Q3.12 arguments into the unit, predicts erf(x) in Q1.14 with a
// bit-exact fixed-point model of its own, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_error_function_approx_unit;
  import efa_pkg::*;

  localparam int LATENCY    = 102;
  localparam int STALL_LIMIT = 5000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;

  // Expected erf values, oldest first.
  logic [DATA_W-1:0] erf_expected[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  quiet_cycles = 0;
  bit  timed_out = 1'b0;

  error_function_approx_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Unsigned shift right with round half up.
  function automatic longint unsigned shr_round(longint unsigned v, int s);
    if (s == 0) return v;
    if (s >= 64) return 0;
    return (v >> s) + ((v >> (s - 1)) & 64'd1);
  endfunction

  function automatic longint coef_fixed(int i);
    longint c;
    longint unsigned m;
    longint unsigned q;
    c = COEF_E8[i];
    m = (c < 0) ? -c : c;
    q = ((m << QB) + COEF_SCALE / 2) / COEF_SCALE;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Q30 product, rounded half away from zero.
  function automatic longint fix_mul(longint a, longint b);
    bit neg;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = shr_round(ma * mb, QB);
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // exp(e) in Q30 via ln2 range reduction and a Taylor series.
  function automatic longint fix_exp(longint e);
    longint k;
    longint r;
    longint unsigned sum;
    longint unsigned term;
    if (e >= 0) k = e / LN2_Q;
    else k = -(((-e) + LN2_Q - 1) / LN2_Q);
    r = e - k * LN2_Q;
    sum = ONE_Q;
    term = ONE_Q;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = shr_round(term * longint'(r), QB);
      term = (term + n / 2) / n;
      sum += term;
    end
    if (k >= 0) return longint'(sum << ((k > 2) ? 2 : k));
    if (-k >= 62) return 0;
    return longint'(shr_round(sum, int'(-k)));
  endfunction

  // erf of a Q3.12 argument as Q1.14.
  function automatic logic [DATA_W-1:0] predict_erf(logic [DATA_W-1:0] arg);
    bit neg;
    longint unsigned mag;
    longint unsigned erf_abs;
    longint unsigned den;
    longint t;
    longint p;
    longint sq;
    longint v;
    longint res;
    neg = arg[DATA_W-1];
    mag = neg ? (64'd65536 - arg) : arg;
    if (mag >= (64'd6 << ARG_FRAC_BITS)) begin
      erf_abs = ONE_Q;
    end else begin
      den = (64'd2 << ARG_FRAC_BITS) + mag;
      t = longint'(((64'd1 << (QB + 1 + ARG_FRAC_BITS)) + den / 2) / den);
      p = coef_fixed(POLY_DEG);
      for (int i = POLY_DEG - 1; i >= 0; i--) p = coef_fixed(i) + fix_mul(p, t);
      sq = longint'((mag * mag) << (QB - 2 * ARG_FRAC_BITS));
      v = ONE_Q - fix_mul(t, fix_exp(p - sq));
      erf_abs = (v < 0) ? 0 : v;
    end
    res = longint'(shr_round(erf_abs, RES_SHIFT));
    if (res > (longint'(1) << RESULT_FRAC_BITS)) res = longint'(1) << RESULT_FRAC_BITS;
    if (neg) res = -res;
    return DATA_W'(res);
  endfunction

  // Send one argument, holding it until the unit takes it.
  task automatic send_arg(logic [DATA_W-1:0] arg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= arg;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    erf_expected.push_back(predict_erf(arg));
    items_sent++;
  endtask

  // Receiver stalls and result checking.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (erf_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", m_tdata);
        end else begin
          logic [DATA_W-1:0] want;
          want = erf_expected.pop_front();
          if (want !== m_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("erf_value mismatch: expected %h, actual %h", want, m_tdata);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("Watchdog expired with %0d results pending", erf_expected.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [DATA_W-1:0] args[$];
    args = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
             16'h6000, 16'h5FFF, 16'hA000, 16'hA001, 16'h1000, 16'hF000,
             16'h0800, 16'h2000, 16'hE000, 16'h3000, 16'h4000, 16'hC000,
             16'h5555, 16'hAAAA, 16'h0010, 16'hFFF0};
    foreach (args[i]) send_arg(args[i]);
  endtask

  // Mostly arguments of magnitude up to 0x6001, just past six, some anywhere.
  task automatic test_random(int count);
    logic [DATA_W-1:0] arg;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) arg = DATA_W'($urandom());
      else begin
        arg = DATA_W'($urandom_range(16'h6001));
        if ($urandom_range(1)) arg = -arg;
      end
      send_arg(arg);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (erf_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 26;
    recv_idle_pct = 46;
    test_directed();
    test_random(510);
    send_idle_pct = 46;
    recv_idle_pct = 26;
    test_random(510);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(510);
    drain();
    $display("Sent %0d arguments over three idle patterns, checked %0d results.",
             items_sent, results_seen);
    if (mismatches == 0 && erf_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
